// ===== rtl/spg_pkg.sv =====
// spg_pkg: shared types, constants and helpers of the sandpile relaxation grid
// used by sandpile_relaxation_grid and spg_checker
// no dependencies
package spg_pkg;

    localparam int GRID_SIZE = 32;
    localparam int GRID_W    = $clog2(GRID_SIZE);
    localparam int ADDR_W    = 2 * GRID_W;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int CELL_W    = 3;
    localparam int COUNT_W   = 16;
    localparam int SWEEP_W   = 16;

    localparam logic [CELL_W-1:0]  CELL_MAX         = 3'd7;
    localparam logic [CELL_W-1:0]  TOPPLE_ABOVE     = 3'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;
    localparam logic [SWEEP_W-1:0] MAX_SWEEPS_RESET = 16'd1024;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [1:0] NB_UP    = 2'd0;
    localparam logic [1:0] NB_DOWN  = 2'd1;
    localparam logic [1:0] NB_LEFT  = 2'd2;
    localparam logic [1:0] NB_RIGHT = 2'd3;

    typedef struct packed {
        logic       func;
        logic [4:0] row;
        logic [4:0] col;
    } spg_in_t;

    typedef struct packed {
        logic [CELL_W-1:0]  cell_value;
        logic [COUNT_W-1:0] topple_count;
        logic               not_stable;
    } spg_out_t;

    function automatic logic [CELL_W-1:0] spg_sat_inc(input logic [CELL_W-1:0] v);
        logic [CELL_W-1:0] r;
        r = (v == CELL_MAX) ? v : v + CELL_W'(1);
        return r;
    endfunction

    // wrapped neighbor address on the torus
    function automatic logic [ADDR_W-1:0] spg_neighbor(input logic [ADDR_W-1:0] a,
                                                       input logic [1:0] sel);
        logic [GRID_W-1:0] r;
        logic [GRID_W-1:0] c;
        logic [ADDR_W-1:0] n;
        r = a[ADDR_W-1:GRID_W];
        c = a[GRID_W-1:0];
        case (sel)
            NB_UP:    n = {r - GRID_W'(1), c};
            NB_DOWN:  n = {r + GRID_W'(1), c};
            NB_LEFT:  n = {r, c - GRID_W'(1)};
            NB_RIGHT: n = {r, c + GRID_W'(1)};
            default:  n = a;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/sandpile_relaxation_grid.sv =====
// sandpile_relaxation_grid: toroidal sandpile grid held in one on-chip memory
// depends on spg_pkg
//
// usage
//   s_ channel takes one word per item: func (add grain or read), row, col
//   m_ channel returns one word per item: cell_value, topple_count, not_stable
//   cfg_ channel writes max_sweeps (reset value 1024); the user is to write it
//   only while the block is idle, the block itself does not enforce this
// processing
//   one item at a time; a read item goes straight to the final read of its cell
//   an add item increments its cell; a sweep decision follows it and each sweep,
//   and a final read ends it; a sweep visits all 1024 cells, one per cycle, and
//   per topple does four neighbor read-modify-writes, one per cycle, on one read port
// reset
//   after aresetn a clearing pass writes zero to all 1024 cells, one a cycle;
//   s_ready stays low during that pass, cfg writes are taken as ever
// stall
//   a finished result waits in the output register until m_ready; the next
//   item is accepted meanwhile and holds in its last step until the slot frees
module sandpile_relaxation_grid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  spg_pkg::spg_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output spg_pkg::spg_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [15:0]      cfg_data
);
    import spg_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_DECIDE,
        ST_CHECK,
        ST_NB,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  cell_reg, cell_next;
    logic [ADDR_W-1:0]  tgt_reg, tgt_next;
    logic [1:0]         nb_reg, nb_next;
    logic [SWEEP_W-1:0] sweeps_reg, sweeps_next;
    logic [COUNT_W-1:0] topples_reg, topples_next;
    logic [CNT_W-1:0]   unstable_reg, unstable_next;
    logic [SWEEP_W-1:0] max_sweeps_reg, max_sweeps_next;
    logic               flag_reg, flag_next;
    logic               m_valid_reg, m_valid_next;
    spg_out_t           m_data_reg, m_data_next;

    logic [CELL_W-1:0]  grid_mem [2**ADDR_W];
    logic [CELL_W-1:0]  mem_rd_reg;
    logic               byp_hit_reg;
    logic [CELL_W-1:0]  byp_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [CELL_W-1:0]  mem_wd;
    logic [ADDR_W-1:0]  mem_ra;
    logic [CELL_W-1:0]  rdata;
    logic [ADDR_W-1:0]  nb_addr;
    logic [ADDR_W-1:0]  in_addr;
    logic               s_accept;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign rdata     = byp_hit_reg ? byp_data_reg : mem_rd_reg;
    assign nb_addr   = spg_neighbor(cell_reg, nb_reg);
    assign in_addr   = {s_data.row[GRID_W-1:0], s_data.col[GRID_W-1:0]};

    // grid memory, one write and one read port, read data registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg   <= grid_mem[mem_ra];
        byp_hit_reg  <= mem_we && (mem_wa == mem_ra);
        byp_data_reg <= mem_wd;
    end

    always_comb begin
        state_next      = state_reg;
        cell_next       = cell_reg;
        tgt_next        = tgt_reg;
        nb_next         = nb_reg;
        sweeps_next     = sweeps_reg;
        topples_next    = topples_reg;
        unstable_next   = unstable_reg;
        flag_next       = flag_reg;
        max_sweeps_next = max_sweeps_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_wa          = cell_reg;
        mem_wd          = '0;
        mem_ra          = tgt_reg;

        if (cfg_valid) begin
            max_sweeps_next = cfg_data;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wa    = cell_reg;
                mem_wd    = '0;
                cell_next = cell_reg + ADDR_W'(1);
                if (&cell_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                mem_ra = in_addr;
                if (s_accept) begin
                    tgt_next     = in_addr;
                    sweeps_next  = '0;
                    topples_next = '0;
                    flag_next    = 1'b0;
                    state_next   = (s_data.func == FUNC_ADD) ? ST_ADD : ST_OUT;
                end
            end
            ST_ADD: begin
                mem_we = 1'b1;
                mem_wa = tgt_reg;
                mem_wd = spg_sat_inc(rdata);
                if (rdata == TOPPLE_ABOVE) begin
                    unstable_next = unstable_reg + CNT_W'(1);
                end
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (unstable_reg == '0) begin
                    mem_ra     = tgt_reg;
                    state_next = ST_OUT;
                end else if (sweeps_reg >= max_sweeps_reg) begin
                    flag_next  = 1'b1;
                    mem_ra     = tgt_reg;
                    state_next = ST_OUT;
                end else begin
                    cell_next  = '0;
                    mem_ra     = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (rdata > TOPPLE_ABOVE) begin
                    mem_we        = 1'b1;
                    mem_wa        = cell_reg;
                    mem_wd        = '0;
                    unstable_next = unstable_reg - CNT_W'(1);
                    if (topples_reg != COUNT_MAX) begin
                        topples_next = topples_reg + COUNT_W'(1);
                    end
                    nb_next    = NB_UP;
                    mem_ra     = spg_neighbor(cell_reg, NB_UP);
                    state_next = ST_NB;
                end else if (&cell_reg) begin
                    sweeps_next = sweeps_reg + SWEEP_W'(1);
                    state_next  = ST_DECIDE;
                end else begin
                    cell_next = cell_reg + ADDR_W'(1);
                    mem_ra    = cell_reg + ADDR_W'(1);
                end
            end
            ST_NB: begin
                mem_we = 1'b1;
                mem_wa = nb_addr;
                mem_wd = spg_sat_inc(rdata);
                if (rdata == TOPPLE_ABOVE) begin
                    unstable_next = unstable_reg + CNT_W'(1);
                end
                if (nb_reg != NB_RIGHT) begin
                    nb_next = nb_reg + 2'd1;
                    mem_ra  = spg_neighbor(cell_reg, nb_reg + 2'd1);
                end else if (&cell_reg) begin
                    sweeps_next = sweeps_reg + SWEEP_W'(1);
                    state_next  = ST_DECIDE;
                end else begin
                    cell_next  = cell_reg + ADDR_W'(1);
                    mem_ra     = cell_reg + ADDR_W'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_OUT: begin
                mem_ra = tgt_reg;
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.cell_value   = rdata;
                    m_data_next.topple_count = topples_reg;
                    m_data_next.not_stable   = flag_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            cell_reg       <= '0;
            nb_reg         <= NB_UP;
            unstable_reg   <= '0;
            max_sweeps_reg <= MAX_SWEEPS_RESET;
            m_valid_reg    <= 1'b0;
            sweeps_reg     <= '0;
            topples_reg    <= '0;
            flag_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cell_reg       <= cell_next;
            nb_reg         <= nb_next;
            unstable_reg   <= unstable_next;
            max_sweeps_reg <= max_sweeps_next;
            m_valid_reg    <= m_valid_next;
            sweeps_reg     <= sweeps_next;
            topples_reg    <= topples_next;
            flag_reg       <= flag_next;
        end
        tgt_reg    <= tgt_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== rtl/spg_checker.sv =====
// spg_checker: port-level checks of sandpile_relaxation_grid, bound to the top level
// depends on spg_pkg
module spg_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input spg_pkg::spg_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input spg_pkg::spg_out_t m_data
);
    import spg_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic       s_acc;
    logic       m_acc;
    spg_in_t    s_seen;

    assign s_acc  = s_valid && s_ready;
    assign m_acc  = m_valid && m_ready;
    assign s_seen = s_data;

    always_comb begin
        pend_next = pend_reg + {1'b0, s_acc} - {1'b0, m_acc};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_busy_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ready or valid high right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_seen.func == FUNC_ADD || s_seen.func == FUNC_READ) |=> !s_ready)
        else $error("new word taken while previous item is at work");

    a_result_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0 && pend_reg != 2'd3)
        else $error("result word without a matching item");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

endmodule

bind sandpile_relaxation_grid spg_checker u_spg_checker (.*);

// ===== test/sandpile_relaxation_grid_test.sv =====
// sandpile_relaxation_grid_test: self-checking bench for the toroidal sandpile grid
// a grain ledger class mirrors the grid, relaxes it per add word and checks each result
// depends on spg_pkg and sandpile_relaxation_grid
module sandpile_relaxation_grid_test;
    import spg_pkg::*;

    class grain_ledger;
        logic [CELL_W*GRID_SIZE*GRID_SIZE-1:0] grid;
        logic [SWEEP_W-1:0] sweep_limit;
        spg_out_t due_results[$];
        int unsigned errors;
        int unsigned adds;
        int unsigned reads;
        int unsigned flagged;
        int unsigned topples_total;
        int unsigned relax_topples;
        int unsigned work;

        function new();
            grid = '0;
            sweep_limit = MAX_SWEEPS_RESET;
            errors = 0;
            adds = 0;
            reads = 0;
            flagged = 0;
            topples_total = 0;
            relax_topples = 0;
            work = 0;
        endfunction

        function logic [CELL_W-1:0] get_grains(int k);
            return grid[k*CELL_W +: CELL_W];
        endfunction

        function void set_grains(int k, logic [CELL_W-1:0] v);
            grid[k*CELL_W +: CELL_W] = v;
        endfunction

        // wrapped neighbor, count sticks at the cell maximum
        function void drop_grain(int r, int c);
            int k;
            k = ((r + GRID_SIZE) % GRID_SIZE) * GRID_SIZE + (c + GRID_SIZE) % GRID_SIZE;
            if (get_grains(k) != CELL_MAX) begin
                set_grains(k, get_grains(k) + 3'd1);
            end
        endfunction

        function bit unsettled();
            for (int k = 0; k < GRID_SIZE * GRID_SIZE; k++) begin
                if (get_grains(k) > TOPPLE_ABOVE) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // one in-place row-major pass
        function void sweep();
            int k;
            for (int r = 0; r < GRID_SIZE; r++) begin
                for (int c = 0; c < GRID_SIZE; c++) begin
                    k = r * GRID_SIZE + c;
                    if (get_grains(k) > TOPPLE_ABOVE) begin
                        set_grains(k, '0);
                        drop_grain(r - 1, c);
                        drop_grain(r + 1, c);
                        drop_grain(r, c - 1);
                        drop_grain(r, c + 1);
                        relax_topples++;
                    end
                end
            end
        endfunction

        function void note_word(spg_in_t w);
            int r;
            int c;
            int done;
            spg_out_t res;
            r = int'(w.row) % GRID_SIZE;
            c = int'(w.col) % GRID_SIZE;
            relax_topples = 0;
            done = 0;
            res = '0;
            if (w.func == FUNC_ADD) begin
                adds++;
                drop_grain(r, c);
                while (unsettled() && !res.not_stable) begin
                    if (done >= sweep_limit) begin
                        res.not_stable = 1'b1;
                    end else begin
                        sweep();
                        done++;
                    end
                end
            end else begin
                reads++;
            end
            res.cell_value = get_grains(r * GRID_SIZE + c);
            res.topple_count = (relax_topples > COUNT_MAX) ? COUNT_MAX
                                                           : COUNT_W'(relax_topples);
            flagged += res.not_stable;
            topples_total += relax_topples;
            work += 6 + done * 1030 + 4 * relax_topples;
            due_results.insert(due_results.size(), res);
        endfunction

        function void check_word(spg_out_t got);
            spg_out_t want;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 30) begin
                    $display("%0t: unexpected word, expected none, actual %0d %0d %0d",
                             $time, got.cell_value, got.topple_count, got.not_stable);
                end
            end else begin
                want = due_results.pop_front();
                if (got.cell_value !== want.cell_value) begin
                    errors++;
                    if (errors <= 30) begin
                        $display("%0t: cell_value expected %0d actual %0d",
                                 $time, want.cell_value, got.cell_value);
                    end
                end
                if (got.topple_count !== want.topple_count) begin
                    errors++;
                    if (errors <= 30) begin
                        $display("%0t: topple_count expected %0d actual %0d",
                                 $time, want.topple_count, got.topple_count);
                    end
                end
                if (got.not_stable !== want.not_stable) begin
                    errors++;
                    if (errors <= 30) begin
                        $display("%0t: not_stable expected %0d actual %0d",
                                 $time, want.not_stable, got.not_stable);
                    end
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    spg_in_t     s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    spg_out_t    m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    grain_ledger ledger;
    int          send_idle_pct;
    int          recv_idle_pct;
    int unsigned cycles = 0;
    logic [15:0] last_limit;

    sandpile_relaxation_grid u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ledger.check_word(m_data);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 300000 + 3 * ledger.work + 400 * (ledger.adds + ledger.reads)) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic spg_in_t make_word(logic func, logic [4:0] row, logic [4:0] col);
        spg_in_t w;
        w.func = func;
        w.row = row;
        w.col = col;
        return w;
    endfunction

    task automatic send_word(input spg_in_t w);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        ledger.note_word(w);
    endtask

    task automatic end_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (ledger.due_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_limit(input logic [15:0] v);
        end_sending();
        wait_drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        ledger.sweep_limit = v;
        last_limit = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // adds cluster in a 6 by 6 window so the pile goes critical
    task automatic run_phase(input int items, input int s_idle, input int r_idle,
                             input logic [15:0] limit);
        logic [4:0] wr;
        logic [4:0] wc;
        int roll;
        write_limit(limit);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        wr = 5'($urandom);
        wc = 5'($urandom);
        for (int i = 0; i < items; i++) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                send_word(make_word(FUNC_ADD, wr + 5'($urandom_range(5)),
                                    wc + 5'($urandom_range(5))));
            end else if (roll < 70) begin
                send_word(make_word(FUNC_ADD, 5'($urandom), 5'($urandom)));
            end else if (roll < 85) begin
                send_word(make_word(FUNC_READ, wr + 5'($urandom_range(5)),
                                    wc + 5'($urandom_range(5))));
            end else begin
                send_word(make_word(FUNC_READ, 5'($urandom), 5'($urandom)));
            end
        end
    endtask

    initial begin
        ledger = new();
        last_limit = MAX_SWEEPS_RESET;
        send_idle_pct = 35;
        recv_idle_pct = 78;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty grid, then a first topple at the corner that wraps both ways
        send_word(make_word(FUNC_READ, 5'd0, 5'd0));
        send_word(make_word(FUNC_READ, 5'd31, 5'd31));
        repeat (4) send_word(make_word(FUNC_ADD, 5'd0, 5'd0));
        send_word(make_word(FUNC_READ, 5'd31, 5'd0));
        send_word(make_word(FUNC_READ, 5'd0, 5'd31));

        // no sweeps allowed: pile up past the topple point and saturate
        write_limit(16'd0);
        repeat (8) send_word(make_word(FUNC_ADD, 5'd5, 5'd5));

        // one sweep relaxes the pile left behind
        write_limit(16'd1);
        send_word(make_word(FUNC_ADD, 5'd5, 5'd5));
        send_word(make_word(FUNC_READ, 5'd5, 5'd6));

        write_limit(16'hFFFF);
        send_word(make_word(FUNC_READ, 5'd17, 5'd10));
        send_word(make_word(FUNC_ADD, 5'd31, 5'd31));

        run_phase(90, 35, 78, 16'd2);
        run_phase(90, 78, 35, 16'hFFFF);
        run_phase(90, 0, 0, 16'($urandom_range(3, 24)));

        end_sending();
        wait_drain();
        repeat (16) @(posedge aclk);

        $display("covered %0d adds and %0d reads, %0d topples, %0d relaxations cut short",
                 ledger.adds, ledger.reads, ledger.topples_total, ledger.flagged);
        $display("sweep limits 1024, 0, 1, 2, 65535 and %0d; %0d mismatches",
                 last_limit, ledger.errors);
        if (ledger.errors == 0 && ledger.due_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
